### rtl/core/nid_pkg.sv
// nid_pkg: types, codes and window helpers for the nec infrared edge decoder
// no dependencies; used by every file in rtl/core

package nid_pkg;

    // widths of the fixed item fields
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned KEY_W   = 8;
    localparam int unsigned CFG_N   = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned BITS_W  = 6;
    localparam int unsigned RPT_W   = 8;

    // repeat handling thresholds, frame length and key check value
    localparam logic [RPT_W-1:0] REPEAT_LIMIT = 8'd10;
    localparam logic [RPT_W-1:0] HOLD_COUNT   = 8'd5;
    localparam logic [BITS_W-1:0] FRAME_BITS  = 6'd32;
    localparam logic [KEY_W-1:0]  KEY_XOR_OK  = 8'hFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_BURST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_SPACE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_SPACE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_REPEAT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PER   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_NEXT_FRAME   = 3'd7;

    // reset values of the windows, packed {max, min}
    localparam logic [TIME_W-1:0] RST_LEAD_BURST   = 32'd6553680;
    localparam logic [TIME_W-1:0] RST_LEAD_SPACE   = 32'd3276840;
    localparam logic [TIME_W-1:0] RST_REPEAT_SPACE = 32'd1769490;
    localparam logic [TIME_W-1:0] RST_FIRST_REPEAT = 32'd29491550;
    localparam logic [TIME_W-1:0] RST_SHORT        = 32'd589827;
    localparam logic [TIME_W-1:0] RST_LONG         = 32'd1441804;
    localparam logic [TIME_W-1:0] RST_REPEAT_PER   = 32'd68813700;
    localparam logic [TIME_W-1:0] RST_NEXT_FRAME   = 32'd68813700;

    typedef logic [CFG_N-1:0][TIME_W-1:0] t_cfg_bank;

    typedef enum logic [CMD_W-1:0] {
        CMD_EDGE       = 2'd0,
        CMD_CLEAR_CONT = 2'd1,
        CMD_CLEAR_ALL  = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        PH_WAIT     = 4'd0,
        PH_LEAD     = 4'd1,
        PH_MARK     = 4'd2,
        PH_SPACE    = 4'd3,
        PH_CHECK    = 4'd4,
        PH_RWAIT    = 4'd5,
        PH_RBURST   = 4'd6,
        PH_RSPACE   = 4'd7,
        PH_RCONFIRM = 4'd8
    } t_phase;

    // flags and codes reported after each item
    typedef struct packed {
        logic              frame_ready;
        logic [ADDR_W-1:0] device_address;
        logic [KEY_W-1:0]  key_code;
        logic              key_held;
        logic              key_continuing;
    } t_result;

    // strict window test: min < d < max, min in low half, max in high half
    function automatic logic in_win(input logic [TIME_W-1:0] d, input logic [TIME_W-1:0] w);
        return (d > {16'd0, w[15:0]}) && (d < {16'd0, w[31:16]});
    endfunction

endpackage

### rtl/core/nid_in_if.sv
// nid_in_if: event channel into the decoder (command and edge timestamp)
// depends on nid_pkg for field widths

interface nid_in_if;
    logic                             valid;
    logic                             ready;
    logic [nid_pkg::CMD_W-1:0]        command;
    logic [nid_pkg::TIME_W-1:0]       edge_time;

    modport source (output valid, output command, output edge_time, input ready);
    modport sink   (input valid, input command, input edge_time, output ready);
endinterface

### rtl/core/nid_out_if.sv
// nid_out_if: result channel out of the decoder (flags, address, key)
// depends on nid_pkg for field widths

interface nid_out_if;
    logic                             valid;
    logic                             ready;
    logic                             frame_ready;
    logic [nid_pkg::ADDR_W-1:0]       device_address;
    logic [nid_pkg::KEY_W-1:0]        key_code;
    logic                             key_held;
    logic                             key_continuing;

    modport source (output valid, output frame_ready, output device_address,
                    output key_code, output key_held, output key_continuing, input ready);
    modport sink   (input valid, input frame_ready, input device_address,
                    input key_code, input key_held, input key_continuing, output ready);
endinterface

### rtl/core/nec_ir_edge_decoder.sv
// nec_ir_edge_decoder: top level of the nec infrared edge-timestamp decoder
// depends on nid_pkg, nid_in_if, nid_out_if, nid_cfg_regs, nid_decode, nid_out_stage

// Each transfer on the event channel carries a command (edge, clear continuing,
// clear all) and a 32-bit edge timestamp in 0.1 ms ticks, and produces exactly
// one result: frame_ready, device_address, key_code, key_held and key_continuing
// as they stand after that event. The block takes one event per clock cycle
// unless the result channel stalls; each result passes the input register, then
// the result register, and the decoder state is updated by a single pass of window
// compares per event. Timing windows are written through the configuration port
// as {max[31:16], min[15:0]} with strict bounds, and should be written only while
// no event is in flight. No clearing pass is needed after reset.

module nec_ir_edge_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [nid_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [nid_pkg::TIME_W-1:0]      i_cfg_wdata,
    nid_in_if.sink                          i_evt,
    nid_out_if.source                       o_res
);

    logic                           r_in_valid;
    logic [nid_pkg::CMD_W-1:0]      r_in_command;
    logic [nid_pkg::TIME_W-1:0]     r_in_time;
    logic                           out_can_load;
    logic                           advance;
    nid_pkg::t_cfg_bank             cfg;
    nid_pkg::t_result               result;

    // input register moves on whenever the result register can take its result
    assign advance     = r_in_valid && out_can_load;
    assign i_evt.ready = !r_in_valid || out_can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_evt.ready) begin
            r_in_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.ready && i_evt.valid) begin
            r_in_command <= i_evt.command;
            r_in_time    <= i_evt.edge_time;
        end
    end

    // timing window bank
    nid_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_wr_en),
        .i_index (i_cfg_index),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    // frame decoder
    nid_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (advance),
        .i_command   (r_in_command),
        .i_edge_time (r_in_time),
        .i_cfg       (cfg),
        .o_result    (result)
    );

    // result register
    nid_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_result   (result),
        .o_can_load (out_can_load),
        .o_res      (o_res)
    );

endmodule

### rtl/core/nid_cfg_regs.sv
// nid_cfg_regs: bank of eight packed timing windows with a plain write port
// depends on nid_pkg

module nid_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_en,
    input  logic [nid_pkg::CFG_IDX_W-1:0]   i_index,
    input  logic [nid_pkg::TIME_W-1:0]      i_wdata,
    output nid_pkg::t_cfg_bank              o_cfg
);

    nid_pkg::t_cfg_bank r_cfg;

    // window registers, loaded with the nominal nec timings at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[nid_pkg::CFG_LEAD_BURST]   <= nid_pkg::RST_LEAD_BURST;
            r_cfg[nid_pkg::CFG_LEAD_SPACE]   <= nid_pkg::RST_LEAD_SPACE;
            r_cfg[nid_pkg::CFG_REPEAT_SPACE] <= nid_pkg::RST_REPEAT_SPACE;
            r_cfg[nid_pkg::CFG_FIRST_REPEAT] <= nid_pkg::RST_FIRST_REPEAT;
            r_cfg[nid_pkg::CFG_SHORT]        <= nid_pkg::RST_SHORT;
            r_cfg[nid_pkg::CFG_LONG]         <= nid_pkg::RST_LONG;
            r_cfg[nid_pkg::CFG_REPEAT_PER]   <= nid_pkg::RST_REPEAT_PER;
            r_cfg[nid_pkg::CFG_NEXT_FRAME]   <= nid_pkg::RST_NEXT_FRAME;
        end else if (i_wr_en) begin
            r_cfg[i_index] <= i_wdata;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/core/nid_decode.sv
// nid_decode: frame state machine, decoder state and next-result logic
// depends on nid_pkg; fed by the input register, drives the result register

module nid_decode (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [nid_pkg::CMD_W-1:0]       i_command,
    input  logic [nid_pkg::TIME_W-1:0]      i_edge_time,
    input  nid_pkg::t_cfg_bank              i_cfg,
    output nid_pkg::t_result                o_result
);

    nid_pkg::t_phase                r_phase, n_phase;
    logic [nid_pkg::TIME_W-1:0]     r_last_edge, n_last_edge;
    logic [nid_pkg::TIME_W-1:0]     r_last_frame, n_last_frame;
    logic [nid_pkg::TIME_W-1:0]     r_shift_word, n_shift_word;
    logic [nid_pkg::TIME_W-1:0]     r_prev_word, n_prev_word;
    logic [nid_pkg::BITS_W-1:0]     r_bits_taken, n_bits_taken;
    logic [nid_pkg::RPT_W-1:0]      r_repeat_count, n_repeat_count;
    logic                           r_recheck, n_recheck;
    logic                           r_ready_flag, n_ready_flag;
    logic [nid_pkg::ADDR_W-1:0]     r_address, n_address;
    logic [nid_pkg::KEY_W-1:0]      r_key, n_key;
    logic                           r_held_flag, n_held_flag;
    logic                           r_continuing, n_continuing;

    logic [nid_pkg::TIME_W-1:0]     d_edge;
    logic [nid_pkg::TIME_W-1:0]     d_frame;
    logic                           win_lead_burst, win_lead_space, win_rpt_space;
    logic                           win_first_rpt, win_short, win_long;
    logic                           win_rpt_per, win_next_frame, below_next_frame;
    logic                           key_ok;
    logic [nid_pkg::BITS_W-1:0]     bits_inc;
    logic [nid_pkg::RPT_W-1:0]      rpt_inc;

    // interval measurement, wrapping 32-bit subtraction
    assign d_edge  = i_edge_time - r_last_edge;
    assign d_frame = i_edge_time - r_last_frame;

    // all window compares in parallel
    assign win_lead_burst = nid_pkg::in_win(d_edge, i_cfg[nid_pkg::CFG_LEAD_BURST]);
    assign win_lead_space = nid_pkg::in_win(d_edge, i_cfg[nid_pkg::CFG_LEAD_SPACE]);
    assign win_rpt_space  = nid_pkg::in_win(d_edge, i_cfg[nid_pkg::CFG_REPEAT_SPACE]);
    assign win_first_rpt  = nid_pkg::in_win(d_frame, i_cfg[nid_pkg::CFG_FIRST_REPEAT]);
    assign win_short      = nid_pkg::in_win(d_edge, i_cfg[nid_pkg::CFG_SHORT]);
    assign win_long       = nid_pkg::in_win(d_edge, i_cfg[nid_pkg::CFG_LONG]);
    assign win_rpt_per    = nid_pkg::in_win(d_edge, i_cfg[nid_pkg::CFG_REPEAT_PER]);
    assign win_next_frame = nid_pkg::in_win(d_edge, i_cfg[nid_pkg::CFG_NEXT_FRAME]);
    assign below_next_frame = d_edge < {16'd0, i_cfg[nid_pkg::CFG_NEXT_FRAME][15:0]};

    // command byte against its inverse
    assign key_ok   = (r_shift_word[23:16] ^ r_shift_word[31:24]) == nid_pkg::KEY_XOR_OK;
    assign bits_inc = r_bits_taken + 6'd1;
    assign rpt_inc  = r_repeat_count + 8'd1;

    // next state for one transfer
    always_comb begin
        n_phase        = r_phase;
        n_last_edge    = r_last_edge;
        n_last_frame   = r_last_frame;
        n_shift_word   = r_shift_word;
        n_prev_word    = r_prev_word;
        n_bits_taken   = r_bits_taken;
        n_repeat_count = r_repeat_count;
        n_recheck      = r_recheck;
        n_ready_flag   = r_ready_flag;
        n_address      = r_address;
        n_key          = r_key;
        n_held_flag    = r_held_flag;
        n_continuing   = r_continuing;
        if (i_valid) begin
            unique case (nid_pkg::t_cmd'(i_command))
                nid_pkg::CMD_EDGE: begin
                    unique case (r_phase)
                        nid_pkg::PH_WAIT: begin
                            if (win_lead_burst) begin
                                n_phase = nid_pkg::PH_LEAD;
                            end
                            n_last_edge = i_edge_time;
                        end
                        nid_pkg::PH_LEAD: begin
                            if (win_lead_space) begin
                                n_last_edge  = i_edge_time;
                                n_bits_taken = '0;
                                n_continuing = 1'b1;
                                n_phase      = nid_pkg::PH_MARK;
                            end else if (win_rpt_space && win_first_rpt) begin
                                n_phase        = nid_pkg::PH_RCONFIRM;
                                n_repeat_count = '0;
                            end else begin
                                n_phase = nid_pkg::PH_WAIT;
                            end
                        end
                        nid_pkg::PH_MARK: begin
                            if (win_short) begin
                                n_last_edge = i_edge_time;
                                n_phase     = nid_pkg::PH_SPACE;
                            end else begin
                                n_phase = nid_pkg::PH_WAIT;
                            end
                        end
                        nid_pkg::PH_SPACE: begin
                            // short space is a zero, long space a one, lsb first
                            if (win_short || win_long) begin
                                n_last_edge  = i_edge_time;
                                n_shift_word = {win_long && !win_short, r_shift_word[31:1]};
                                n_bits_taken = bits_inc;
                                n_phase      = (bits_inc == nid_pkg::FRAME_BITS) ?
                                               nid_pkg::PH_CHECK : nid_pkg::PH_MARK;
                            end else begin
                                n_phase = nid_pkg::PH_WAIT;
                            end
                        end
                        nid_pkg::PH_CHECK: begin
                            // trailing edge only triggers the frame check
                            if (!r_recheck) begin
                                if (key_ok) begin
                                    n_last_frame = r_last_edge;
                                    n_ready_flag = 1'b1;
                                    n_address    = r_shift_word[15:0];
                                    n_key        = r_shift_word[23:16];
                                    n_continuing = 1'b1;
                                end
                                n_prev_word = r_shift_word;
                            end else begin
                                if (r_shift_word == r_prev_word) begin
                                    n_last_frame = r_last_edge;
                                    n_continuing = 1'b1;
                                end
                                n_recheck = 1'b0;
                            end
                            n_phase = nid_pkg::PH_WAIT;
                        end
                        nid_pkg::PH_RWAIT: begin
                            if ((r_repeat_count < nid_pkg::REPEAT_LIMIT) && win_rpt_per) begin
                                n_last_edge = i_edge_time;
                                n_phase     = nid_pkg::PH_RBURST;
                            end else if ((r_repeat_count == nid_pkg::REPEAT_LIMIT) &&
                                         win_next_frame) begin
                                n_last_edge = i_edge_time;
                                n_recheck   = 1'b1;
                                n_phase     = nid_pkg::PH_WAIT;
                            end else if (!below_next_frame) begin
                                n_last_edge = i_edge_time;
                                n_phase     = nid_pkg::PH_WAIT;
                            end
                        end
                        nid_pkg::PH_RBURST: begin
                            if (win_lead_burst) begin
                                n_last_edge = i_edge_time;
                                n_phase     = nid_pkg::PH_RSPACE;
                            end else begin
                                n_phase = nid_pkg::PH_WAIT;
                            end
                        end
                        nid_pkg::PH_RSPACE: begin
                            n_phase = win_rpt_space ? nid_pkg::PH_RCONFIRM : nid_pkg::PH_WAIT;
                        end
                        nid_pkg::PH_RCONFIRM: begin
                            n_last_edge    = i_edge_time;
                            n_repeat_count = rpt_inc;
                            if (rpt_inc == nid_pkg::HOLD_COUNT) begin
                                n_held_flag = 1'b1;
                            end
                            n_continuing = 1'b1;
                            n_phase      = nid_pkg::PH_RWAIT;
                        end
                        default: begin
                            n_phase = nid_pkg::PH_WAIT;
                        end
                    endcase
                end
                nid_pkg::CMD_CLEAR_CONT: begin
                    n_continuing = 1'b0;
                end
                nid_pkg::CMD_CLEAR_ALL: begin
                    n_ready_flag = 1'b0;
                    n_address    = '0;
                    n_key        = '0;
                    n_held_flag  = 1'b0;
                    n_continuing = 1'b0;
                end
                default: begin
                    // unused code leaves the state alone
                end
            endcase
        end
    end

    // decoder state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= nid_pkg::PH_WAIT;
            r_last_edge    <= '0;
            r_last_frame   <= '0;
            r_shift_word   <= '0;
            r_prev_word    <= '0;
            r_bits_taken   <= '0;
            r_repeat_count <= '0;
            r_recheck      <= 1'b0;
            r_ready_flag   <= 1'b0;
            r_address      <= '0;
            r_key          <= '0;
            r_held_flag    <= 1'b0;
            r_continuing   <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_last_edge    <= n_last_edge;
            r_last_frame   <= n_last_frame;
            r_shift_word   <= n_shift_word;
            r_prev_word    <= n_prev_word;
            r_bits_taken   <= n_bits_taken;
            r_repeat_count <= n_repeat_count;
            r_recheck      <= n_recheck;
            r_ready_flag   <= n_ready_flag;
            r_address      <= n_address;
            r_key          <= n_key;
            r_held_flag    <= n_held_flag;
            r_continuing   <= n_continuing;
        end
    end

    // result reports the flags after this transfer
    always_comb begin
        o_result.frame_ready    = n_ready_flag;
        o_result.device_address = n_address;
        o_result.key_code       = n_key;
        o_result.key_held       = n_held_flag;
        o_result.key_continuing = n_continuing;
    end

`ifndef ASSERT_OFF
    a_bits_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits_taken <= nid_pkg::FRAME_BITS)
        else $error("bit counter ran past a full frame");

    a_check_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == nid_pkg::PH_CHECK) |-> (r_bits_taken == nid_pkg::FRAME_BITS))
        else $error("frame check reached without 32 bits");

    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_command == nid_pkg::CMD_CLEAR_ALL)) |=>
        (!r_ready_flag && !r_held_flag && !r_continuing && (r_address == '0) && (r_key == '0)))
        else $error("clear-all left decoded outputs set");

    a_repeat_confirm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_command == nid_pkg::CMD_EDGE) && (r_phase == nid_pkg::PH_RCONFIRM)) |=>
        ((r_phase == nid_pkg::PH_RWAIT) && r_continuing && (r_repeat_count == $past(rpt_inc))))
        else $error("repeat confirm did not count the repeat");
`endif

endmodule

### rtl/core/nid_out_stage.sv
// nid_out_stage: result register between the decoder and the result channel
// depends on nid_pkg and nid_out_if

module nid_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  nid_pkg::t_result    i_result,
    output logic                o_can_load,
    nid_out_if.source           o_res
);

    logic               r_valid;
    nid_pkg::t_result   r_result;

    // free when empty or when the held result is taken this cycle
    assign o_can_load = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    // result payload, loaded with each transfer out of the decoder
    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.frame_ready    = r_result.frame_ready;
    assign o_res.device_address = r_result.device_address;
    assign o_res.key_code       = r_result.key_code;
    assign o_res.key_held       = r_result.key_held;
    assign o_res.key_continuing = r_result.key_continuing;

endmodule
